[rtl/core/hadf_pkg.sv]
// ----------------------------------------------------------------------------
// hadf_pkg: shared codes for the handle allocator
// Command kinds, result status codes and per-ID life-state encodings.
// ----------------------------------------------------------------------------
package hadf_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned ENT_W    = 8;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned GEN_O_W  = 8;
  localparam int unsigned CNT_O_W  = 9;
  localparam int unsigned LIFE_W   = 2;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DESTROY = 3'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SWEEP   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESET   = 3'd4;

  // result status
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd2;

  // per-ID life state
  localparam logic [LIFE_W-1:0] LS_DEAD    = 2'd0;
  localparam logic [LIFE_W-1:0] LS_ALIVE   = 2'd1;
  localparam logic [LIFE_W-1:0] LS_PENDING = 2'd2;

endpackage

[rtl/core/handle_allocator_deferred_free.sv]
// ----------------------------------------------------------------------------
// handle_allocator_deferred_free: free-stack handle allocator
// Hands out IDs from a stack of free IDs with per-ID generation counts;
// destroyed IDs stay pending until a cleanup sweep returns them.
// ----------------------------------------------------------------------------
// Usage:
//   A command (kind_i, entity_i) is taken at a rising edge with start_i high
//   and busy_o low. Exactly one result per command appears on the result
//   ports for one cycle, marked by done_o; the receiver cannot stall it.
//   busy_o is low again in the done_o cycle, so a new command may be taken
//   at the edge that ends it.
//   Path from acceptance to done_o: create via S_CR_ID and S_CR_WR,
//     destroy/query via S_LOOK, create on empty stack and unused kinds
//     from S_IDLE, cleanup sweep via S_SWEEP, reset-all via S_INIT.
//   The per-ID tables sit in three single-port-write, registered-read
//   memories walked by one sequencer; sweep and reset-all touch one ID per
//   cycle, which sets their length.
//   After rst_ni the block runs a clearing pass over all NUM_IDS IDs (one ID
//   per cycle) with busy_o high before the first command is taken.
// ----------------------------------------------------------------------------
module handle_allocator_deferred_free #(
  parameter int unsigned NUM_IDS  = 256,
  parameter int unsigned GEN_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [hadf_pkg::KIND_W-1:0]   kind_i,
  input  logic [hadf_pkg::ENT_W-1:0]    entity_i,
  output logic                          done_o,
  output logic [hadf_pkg::STAT_W-1:0]   status_o,
  output logic [hadf_pkg::ENT_W-1:0]    entity_id_o,
  output logic [hadf_pkg::GEN_O_W-1:0]  generation_o,
  output logic                          is_alive_o,
  output logic [hadf_pkg::CNT_O_W-1:0]  active_count_o,
  output logic [hadf_pkg::CNT_O_W-1:0]  freed_count_o
);

  localparam int unsigned IW = $clog2(NUM_IDS);
  localparam int unsigned CW = $clog2(NUM_IDS + 1);
  localparam int unsigned EW = hadf_pkg::ENT_W;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CR_ID,
    S_CR_WR,
    S_LOOK,
    S_SWEEP
  } state_e;

  // memories
  logic [hadf_pkg::LIFE_W-1:0] life_mem [NUM_IDS];
  logic [GEN_BITS-1:0]         gen_mem  [NUM_IDS];
  logic [IW-1:0]               stk_mem  [NUM_IDS];

  logic                        life_we, gen_we, stk_we;
  logic [IW-1:0]               life_wa, gen_wa, stk_wa;
  logic [hadf_pkg::LIFE_W-1:0] life_wd;
  logic [GEN_BITS-1:0]         gen_wd;
  logic [IW-1:0]               stk_wd;
  logic [IW-1:0]               life_ra, gen_ra, stk_ra;
  logic [hadf_pkg::LIFE_W-1:0] life_rd_q;
  logic [GEN_BITS-1:0]         gen_rd_q;
  logic [IW-1:0]               stk_rd_q;

  // sequencer state
  state_e               state_q, state_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic                 cmd_q, cmd_d;
  logic [CW-1:0]        top_q, top_d;
  logic [CW-1:0]        live_q, live_d;
  logic [CW-1:0]        frc_q, frc_d;
  logic                 swv_q, swv_d;
  logic [IW-1:0]        swi_q, swi_d;
  logic [IW-1:0]        cid_q, cid_d;
  logic [EW-1:0]        ent_q, ent_d;
  logic                 inr_q, inr_d;
  logic                 dst_q, dst_d;

  // registered result
  logic                         done_q, done_d;
  logic [hadf_pkg::STAT_W-1:0]  status_q, status_d;
  logic [EW-1:0]                eid_q, eid_d;
  logic [GEN_BITS-1:0]          gen_q, gen_d;
  logic                         alive_q, alive_d;
  logic [CW-1:0]                fc_q, fc_d;

  // width helpers
  logic [IW+EW-1:0]       ent_ext_i, ent_ext_q, cid_ext;
  logic                   in_range_i;
  logic [CW-1:0]          top_m1, rev_idx;
  logic [GEN_BITS-1:0]    gen_nx;
  logic [GEN_BITS+7:0]    gen_ext;
  logic [CW+8:0]          live_ext, fc_ext;

  assign ent_ext_i  = {{IW{1'b0}}, entity_i};
  assign ent_ext_q  = {{IW{1'b0}}, ent_q};
  assign cid_ext    = {{EW{1'b0}}, cid_q};
  assign in_range_i = ent_ext_i < (IW+EW)'(NUM_IDS);
  assign top_m1     = top_q - CW'(1);
  assign rev_idx    = CW'(NUM_IDS - 1) - idx_q;
  assign gen_nx     = gen_rd_q + GEN_BITS'(1);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    cmd_d    = cmd_q;
    top_d    = top_q;
    live_d   = live_q;
    frc_d    = frc_q;
    swv_d    = 1'b0;
    swi_d    = swi_q;
    cid_d    = cid_q;
    ent_d    = ent_q;
    inr_d    = inr_q;
    dst_d    = dst_q;
    done_d   = 1'b0;
    status_d = hadf_pkg::ST_DONE;
    eid_d    = '0;
    gen_d    = '0;
    alive_d  = 1'b0;
    fc_d     = '0;

    life_we = 1'b0;
    life_wa = idx_q[IW-1:0];
    life_wd = hadf_pkg::LS_DEAD;
    gen_we  = 1'b0;
    gen_wa  = idx_q[IW-1:0];
    gen_wd  = '0;
    stk_we  = 1'b0;
    stk_wa  = idx_q[IW-1:0];
    stk_wd  = rev_idx[IW-1:0];

    life_ra = ent_ext_i[IW-1:0];
    gen_ra  = ent_ext_i[IW-1:0];
    stk_ra  = top_m1[IW-1:0];

    unique case (state_q)
      S_INIT: begin
        // clear one ID per cycle and rebuild the stack so ID 0 pops first
        life_we = 1'b1;
        gen_we  = 1'b1;
        stk_we  = 1'b1;
        idx_d   = idx_q + CW'(1);
        if (idx_q == CW'(NUM_IDS - 1)) begin
          top_d   = CW'(NUM_IDS);
          live_d  = '0;
          state_d = S_IDLE;
          cmd_d   = 1'b0;
          done_d  = cmd_q;
        end
      end

      S_IDLE: begin
        if (start_i) begin
          unique case (kind_i) inside
            hadf_pkg::KIND_CREATE: begin
              if (top_q == '0) begin
                done_d   = 1'b1;
                status_d = hadf_pkg::ST_FULL;
              end else begin
                top_d   = top_m1;
                state_d = S_CR_ID;
              end
            end
            hadf_pkg::KIND_DESTROY, hadf_pkg::KIND_QUERY: begin
              ent_d   = entity_i;
              inr_d   = in_range_i;
              dst_d   = (kind_i == hadf_pkg::KIND_DESTROY);
              state_d = S_LOOK;
            end
            hadf_pkg::KIND_SWEEP: begin
              idx_d   = '0;
              frc_d   = '0;
              state_d = S_SWEEP;
            end
            hadf_pkg::KIND_RESET: begin
              idx_d   = '0;
              cmd_d   = 1'b1;
              state_d = S_INIT;
            end
            default: begin
              done_d   = 1'b1;
              status_d = hadf_pkg::ST_IGNORED;
            end
          endcase
        end
      end

      S_CR_ID: begin
        // popped ID is here; fetch its generation
        cid_d   = stk_rd_q;
        gen_ra  = stk_rd_q;
        state_d = S_CR_WR;
      end

      S_CR_WR: begin
        gen_we  = 1'b1;
        gen_wa  = cid_q;
        gen_wd  = gen_nx;
        life_we = 1'b1;
        life_wa = cid_q;
        life_wd = hadf_pkg::LS_ALIVE;
        live_d  = live_q + CW'(1);
        done_d  = 1'b1;
        eid_d   = cid_ext[EW-1:0];
        gen_d   = gen_nx;
        alive_d = 1'b1;
        state_d = S_IDLE;
      end

      S_LOOK: begin
        done_d  = 1'b1;
        eid_d   = ent_q;
        state_d = S_IDLE;
        if (inr_q) begin
          gen_d = gen_rd_q;
        end
        if (dst_q) begin
          if (inr_q && life_rd_q == hadf_pkg::LS_ALIVE) begin
            life_we = 1'b1;
            life_wa = ent_ext_q[IW-1:0];
            life_wd = hadf_pkg::LS_PENDING;
          end else begin
            status_d = hadf_pkg::ST_IGNORED;
          end
        end else if (inr_q) begin
          alive_d = (life_rd_q == hadf_pkg::LS_ALIVE);
        end else begin
          status_d = hadf_pkg::ST_IGNORED;
        end
      end

      S_SWEEP: begin
        // issue read of idx_q, act on the ID read last cycle
        life_ra = idx_q[IW-1:0];
        swi_d   = idx_q[IW-1:0];
        if (idx_q != CW'(NUM_IDS)) begin
          swv_d = 1'b1;
          idx_d = idx_q + CW'(1);
        end
        if (swv_q && life_rd_q == hadf_pkg::LS_PENDING) begin
          life_we = 1'b1;
          life_wa = swi_q;
          life_wd = hadf_pkg::LS_DEAD;
          if (top_q != CW'(NUM_IDS)) begin
            stk_we = 1'b1;
            stk_wa = top_q[IW-1:0];
            stk_wd = swi_q;
            top_d  = top_q + CW'(1);
          end
          if (live_q != '0) begin
            live_d = live_q - CW'(1);
          end
          frc_d = frc_q + CW'(1);
        end
        if (idx_q == CW'(NUM_IDS)) begin
          done_d  = 1'b1;
          fc_d    = frc_d;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      idx_q   <= '0;
      cmd_q   <= 1'b0;
      top_q   <= CW'(NUM_IDS);
      live_q  <= '0;
      swv_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cmd_q   <= cmd_d;
      top_q   <= top_d;
      live_q  <= live_d;
      swv_q   <= swv_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frc_q    <= frc_d;
    swi_q    <= swi_d;
    cid_q    <= cid_d;
    ent_q    <= ent_d;
    inr_q    <= inr_d;
    dst_q    <= dst_d;
    status_q <= status_d;
    eid_q    <= eid_d;
    gen_q    <= gen_d;
    alive_q  <= alive_d;
    fc_q     <= fc_d;
  end

  always_ff @(posedge clk_i) begin
    if (life_we) begin
      life_mem[life_wa] <= life_wd;
    end
    life_rd_q <= life_mem[life_ra];
  end

  always_ff @(posedge clk_i) begin
    if (gen_we) begin
      gen_mem[gen_wa] <= gen_wd;
    end
    gen_rd_q <= gen_mem[gen_ra];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd_q <= stk_mem[stk_ra];
  end

  assign gen_ext  = {8'd0, gen_q};
  assign live_ext = {9'd0, live_q};
  assign fc_ext   = {9'd0, fc_q};

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign entity_id_o    = eid_q;
  assign generation_o   = gen_ext[7:0];
  assign is_alive_o     = alive_q;
  assign active_count_o = live_ext[8:0];
  assign freed_count_o  = fc_ext[8:0];

  // every accepted command either keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted command neither busy nor answered");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while sequencer busy");

  // free IDs plus allocated-unswept IDs account for every ID between commands
  a_conserve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |->
      (({1'b0, top_q} + {1'b0, live_q}) == (CW+1)'(NUM_IDS)))
    else $error("free stack and active count out of balance");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == hadf_pkg::ST_FULL) |-> (live_q == CW'(NUM_IDS)))
    else $error("full reported with IDs unaccounted");

endmodule
